// File: hdl/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ssd_pkg;
   localparam int COORD_BITS_DEF = 16;
   localparam int PARAM_FRAC_BITS_DEF = 16;
   localparam int TOL_BITS = 16;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd66;
   localparam int DIST_BITS = 36;
   // quotient bits resolved per divider stage
   localparam int DIV_STEPS = 3;
endpackage
`default_nettype wire

// File: hdl/ssd_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ssd_req_if #(parameter int CB = ssd_pkg::COORD_BITS_DEF);
   logic valid;
   logic ready;
   logic signed [CB-1:0] first_start_x, first_start_y, first_end_x, first_end_y;
   logic signed [CB-1:0] second_start_x, second_start_y, second_end_x, second_end_y;
   modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
      second_start_x, second_start_y, second_end_x, second_end_y, input ready);
   modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
      second_start_x, second_start_y, second_end_x, second_end_y, output ready);
endinterface

interface ssd_rsp_if;
   logic valid;
   logic ready;
   logic [ssd_pkg::DIST_BITS-1:0] dist_sq;
   logic saturated;
   modport source (output valid, dist_sq, saturated, input ready);
   modport sink (input valid, dist_sq, saturated, output ready);
endinterface
`default_nettype wire

// File: hdl/segment_segment_distance_sq_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Squared minimum distance between two 2D segments (Q.4 coordinates, Q.8 result with
// saturation flag). Fully pipelined: one segment pair per cycle unless the result side
// stalls. The stage chain is differences, dot products, determinant and numerator
// products, clamping, six stages of parameter division at the default widths (three
// quotient bits each, two in the last), closest-point difference and final squaring.
// A stall on the result side holds every stage; the user writes zero_tolerance through
// csr_ only while the block is idle, and the block itself does not enforce this.

// pipelined restoring division num/den into [0, 1] with PF fraction bits
module ssd_div #(
   parameter int WB = 4*ssd_pkg::COORD_BITS_DEF + 10,
   parameter int PF = ssd_pkg::PARAM_FRAC_BITS_DEF,
   parameter int TB = ssd_pkg::TOL_BITS,
   parameter int STEPS = ssd_pkg::DIV_STEPS,
   parameter int STAGES = (PF + STEPS) / STEPS
) (
   input  wire logic clock,
   input  wire logic adv,
   input  wire logic [TB-1:0] tol,
   input  wire logic signed [WB-1:0] num,
   input  wire logic signed [WB-1:0] den,
   output logic [PF:0] q
);
   localparam int QB = PF + 1;

   logic signed [WB-1:0] num_abs;
   logic zero_in, one_in;

   // forced results; the bit loop only matters for 0 <= num <= den
   always_comb begin
      num_abs = num[WB-1] ? -num : num;
      zero_in = (num_abs < $signed({{(WB-TB){1'b0}}, tol})) || (den <= 0) || num[WB-1];
      one_in = num > den;
   end

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      localparam int NB = (QB - k*STEPS < STEPS) ? QB - k*STEPS : STEPS;
      logic signed [WB-1:0] rem_src, den_src, rem_in;
      logic [QB-1:0] q_src, q_in;
      logic zero_src, one_src;
      logic [QB-1:0] q_ff;
      logic zero_ff, one_ff;

      if (k == 0) begin : g_first
         assign rem_src = num;
         assign den_src = den;
         assign q_src = '0;
         assign zero_src = zero_in;
         assign one_src = one_in;
      end else begin : g_next
         assign rem_src = g_stage[k-1].g_carry.rem_ff;
         assign den_src = g_stage[k-1].g_carry.den_ff;
         assign q_src = g_stage[k-1].q_ff;
         assign zero_src = g_stage[k-1].zero_ff;
         assign one_src = g_stage[k-1].one_ff;
      end

      always_comb begin
         rem_in = rem_src;
         q_in = q_src;
         for (int i = 0; i < NB; i++) begin
            q_in = {q_in[QB-2:0], 1'b0};
            if (rem_in >= den_src) begin
               rem_in = rem_in - den_src;
               q_in[0] = 1'b1;
            end
            rem_in = rem_in <<< 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff <= q_in;
            zero_ff <= zero_src;
            one_ff <= one_src;
         end
      end

      if (k < STAGES-1) begin : g_carry
         logic signed [WB-1:0] rem_ff, den_ff;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff <= rem_in;
               den_ff <= den_src;
            end
         end
      end
   end

   assign q = g_stage[STAGES-1].zero_ff ? '0 :
              g_stage[STAGES-1].one_ff ? {1'b1, {PF{1'b0}}} : g_stage[STAGES-1].q_ff;
endmodule

module segment_segment_distance_sq_core #(
   parameter int COORD_BITS = ssd_pkg::COORD_BITS_DEF,
   parameter int PARAM_FRAC_BITS = ssd_pkg::PARAM_FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic [ssd_pkg::TOL_BITS-1:0] csr_wdata,
   ssd_req_if.sink   req,
   ssd_rsp_if.source rsp
);
   localparam int DB = COORD_BITS + 1;
   localparam int PB = 2*DB + 2;
   localparam int WB = 2*PB + 2;
   localparam int PF = PARAM_FRAC_BITS;
   localparam int DXB = DB + PF + 3;
   localparam int DIV_STEPS = ssd_pkg::DIV_STEPS;
   localparam int DS = (PF + DIV_STEPS) / DIV_STEPS;
   localparam int NS = DS + 6;
   localparam int GB = 6*DB;

   logic [ssd_pkg::TOL_BITS-1:0] tol_ff;
   logic [NS-1:0] vld_ff;
   logic adv;

   always_ff @(posedge clock) begin
      if (reset) tol_ff <= ssd_pkg::TOL_RESET;
      else if (csr_we) tol_ff <= csr_wdata;
   end

   assign adv = !vld_ff[NS-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NS-2:0], req.valid};
   end

   // stage 1: differences
   logic signed [DB-1:0] ux_ff, uy_ff, vx_ff, vy_ff, wx_ff, wy_ff;
   always_ff @(posedge clock) if (adv) begin
      ux_ff <= DB'(req.first_end_x) - DB'(req.first_start_x);
      uy_ff <= DB'(req.first_end_y) - DB'(req.first_start_y);
      vx_ff <= DB'(req.second_end_x) - DB'(req.second_start_x);
      vy_ff <= DB'(req.second_end_y) - DB'(req.second_start_y);
      wx_ff <= DB'(req.first_start_x) - DB'(req.second_start_x);
      wy_ff <= DB'(req.first_start_y) - DB'(req.second_start_y);
   end

   // stage 2: dot products
   logic signed [PB-1:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic signed [DB-1:0] ux2_ff, uy2_ff, vx2_ff, vy2_ff, wx2_ff, wy2_ff;
   always_ff @(posedge clock) if (adv) begin
      a_ff <= PB'(ux_ff*ux_ff) + PB'(uy_ff*uy_ff);
      b_ff <= PB'(ux_ff*vx_ff) + PB'(uy_ff*vy_ff);
      c_ff <= PB'(vx_ff*vx_ff) + PB'(vy_ff*vy_ff);
      d_ff <= PB'(ux_ff*wx_ff) + PB'(uy_ff*wy_ff);
      e_ff <= PB'(vx_ff*wx_ff) + PB'(vy_ff*wy_ff);
      {ux2_ff, uy2_ff, vx2_ff, vy2_ff, wx2_ff, wy2_ff} <=
         {ux_ff, uy_ff, vx_ff, vy_ff, wx_ff, wy_ff};
   end

   // stage 3: determinant and numerator products
   logic signed [WB-1:0] det_in, sn0_in, tn0_in;
   always_comb begin
      det_in = WB'(a_ff*c_ff) - WB'(b_ff*b_ff);
      sn0_in = WB'(b_ff*e_ff) - WB'(c_ff*d_ff);
      tn0_in = WB'(a_ff*e_ff) - WB'(b_ff*d_ff);
   end
   logic signed [WB-1:0] det_ff, sn0_ff, tn0_ff;
   logic signed [PB-1:0] a3_ff, b3_ff, c3_ff, d3_ff, e3_ff;
   logic signed [DB-1:0] ux3_ff, uy3_ff, vx3_ff, vy3_ff, wx3_ff, wy3_ff;
   always_ff @(posedge clock) if (adv) begin
      det_ff <= det_in; sn0_ff <= sn0_in; tn0_ff <= tn0_in;
      a3_ff <= a_ff; b3_ff <= b_ff; c3_ff <= c_ff; d3_ff <= d_ff; e3_ff <= e_ff;
      {ux3_ff, uy3_ff, vx3_ff, vy3_ff, wx3_ff, wy3_ff} <=
         {ux2_ff, uy2_ff, vx2_ff, vy2_ff, wx2_ff, wy2_ff};
   end

   // stage 4: clamp numerators to the segment ends
   logic signed [WB-1:0] sn_in, sd_in, tn_in, td_in;
   logic signed [PB:0] m;
   logic signed [WB-1:0] det_abs;
   always_comb begin
      det_abs = det_ff[WB-1] ? -det_ff : det_ff;
      sd_in = det_ff; td_in = det_ff;
      if (det_abs < WB'(tol_ff)) begin
         sn_in = '0; sd_in = WB'(1) <<< 16;
         tn_in = WB'(e3_ff) <<< 8; td_in = WB'(c3_ff) <<< 8;
      end else begin
         sn_in = sn0_ff; tn_in = tn0_ff;
         if (sn0_ff[WB-1]) begin
            sn_in = '0; tn_in = WB'(e3_ff) <<< 8; td_in = WB'(c3_ff) <<< 8;
         end else if (sn0_ff > det_ff) begin
            sn_in = det_ff; tn_in = WB'(PB'(e3_ff + b3_ff)) <<< 8; td_in = WB'(c3_ff) <<< 8;
         end
      end
      m = '0;
      if (tn_in[WB-1]) m = -(PB+1)'(d3_ff);
      else if (tn_in > td_in) m = (PB+1)'(b3_ff) - (PB+1)'(d3_ff);
      if (tn_in[WB-1] || tn_in > td_in) begin
         tn_in = tn_in[WB-1] ? '0 : td_in;
         if (m < 0) sn_in = '0;
         else if (m > (PB+1)'(a3_ff)) sn_in = sd_in;
         else begin
            sn_in = WB'(m) <<< 8; sd_in = WB'(a3_ff) <<< 8;
         end
      end
   end
   logic signed [WB-1:0] sn_ff, sd_ff, tn_ff, td_ff;
   logic signed [DB-1:0] ux4_ff, uy4_ff, vx4_ff, vy4_ff, wx4_ff, wy4_ff;
   always_ff @(posedge clock) if (adv) begin
      sn_ff <= sn_in; sd_ff <= sd_in; tn_ff <= tn_in; td_ff <= td_in;
      {ux4_ff, uy4_ff, vx4_ff, vy4_ff, wx4_ff, wy4_ff} <=
         {ux3_ff, uy3_ff, vx3_ff, vy3_ff, wx3_ff, wy3_ff};
   end

   // parameter division, DS stages
   logic [PF:0] s_q, t_q;
   ssd_div #(.WB(WB), .PF(PF), .TB(ssd_pkg::TOL_BITS), .STEPS(DIV_STEPS), .STAGES(DS))
      u_sdiv (.clock(clock), .adv(adv), .tol(tol_ff), .num(sn_ff), .den(sd_ff), .q(s_q));
   ssd_div #(.WB(WB), .PF(PF), .TB(ssd_pkg::TOL_BITS), .STEPS(DIV_STEPS), .STAGES(DS))
      u_tdiv (.clock(clock), .adv(adv), .tol(tol_ff), .num(tn_ff), .den(td_ff), .q(t_q));

   // segment vectors ride alongside the divider
   logic [GB-1:0] geo_dly_ff [DS];
   always_ff @(posedge clock) begin
      if (adv) begin
         geo_dly_ff[0] <= {ux4_ff, uy4_ff, vx4_ff, vy4_ff, wx4_ff, wy4_ff};
         for (int i = 1; i < DS; i++) geo_dly_ff[i] <= geo_dly_ff[i-1];
      end
   end
   logic signed [DB-1:0] uxd, uyd, vxd, vyd, wxd, wyd;
   assign {uxd, uyd, vxd, vyd, wxd, wyd} = geo_dly_ff[DS-1];

   // closest-point difference
   logic signed [DXB-1:0] dx_ff, dy_ff;
   always_ff @(posedge clock) if (adv) begin
      dx_ff <= (DXB'(wxd) <<< PF) + DXB'(uxd * $signed({1'b0, s_q}))
             - DXB'(vxd * $signed({1'b0, t_q}));
      dy_ff <= (DXB'(wyd) <<< PF) + DXB'(uyd * $signed({1'b0, s_q}))
             - DXB'(vyd * $signed({1'b0, t_q}));
   end

   // square, scale, saturate
   logic [2*DXB:0] sq;
   logic [2*DXB:0] sh;
   always_comb begin
      sq = (2*DXB+1)'(dx_ff*dx_ff) + (2*DXB+1)'(dy_ff*dy_ff);
      sh = sq >> (2*PF);
   end
   logic [ssd_pkg::DIST_BITS-1:0] dist_ff;
   logic sat_ff;
   always_ff @(posedge clock) if (adv) begin
      sat_ff <= (sh >> ssd_pkg::DIST_BITS) != '0;
      dist_ff <= ((sh >> ssd_pkg::DIST_BITS) != '0) ? '1 : sh[ssd_pkg::DIST_BITS-1:0];
   end

   assign rsp.valid = vld_ff[NS-1];
   assign rsp.dist_sq = dist_ff;
   assign rsp.saturated = sat_ff;
endmodule
`default_nettype wire

// File: tb/segment_segment_distance_sq_core_test.sv
`timescale 1ns / 1ps
module segment_segment_distance_sq_core_test;
   localparam int CB = ssd_pkg::COORD_BITS_DEF;
   localparam int PFB = ssd_pkg::PARAM_FRAC_BITS_DEF;
   localparam int OB = ssd_pkg::DIST_BITS;
   localparam int TOLB = ssd_pkg::TOL_BITS;
   localparam int LATENCY = 12;
   localparam int STALL_LIMIT = 5000;
   localparam logic [OB-1:0] DIST_MAX = {OB{1'b1}};

   typedef logic signed [127:0] wide_type;
   typedef logic signed [CB-1:0] coord_type;
   typedef coord_type pair_type [8];

   typedef struct {
      logic [OB-1:0] dist_sq;
      logic saturated;
   } dist_result_type;

   class distance_scoreboard;
      dist_result_type pending[$];
      logic [TOLB-1:0] tolerance;
      int errors;
      int checked;

      function new();
         tolerance = ssd_pkg::TOL_RESET;
         errors = 0;
         checked = 0;
      endfunction

      function automatic bit is_small(wide_type x);
         wide_type ax;
         wide_type tw;
         ax = (x < 0) ? -x : x;
         tw = tolerance;
         return ax < tw;
      endfunction

      // clamped quotient num/den in [0, 1]
      function automatic wide_type clamp_ratio(wide_type num, wide_type den);
         wide_type q;
         q = 0;
         if (is_small(num) || den <= 0 || num < 0) return 0;
         if (num > den) return wide_type'(1) <<< PFB;
         for (int i = 0; i <= PFB; i++) begin
            q = q <<< 1;
            if (num >= den) begin
               num = num - den;
               q = q | 1;
            end
            num = num <<< 1;
         end
         return q;
      endfunction

      function automatic dist_result_type closest_dist_sq(pair_type p);
         wide_type ux, uy, vx, vy, wx, wy, a, b, c, d, e, det;
         wide_type sn, sd, tn, td, m, s, t, dx, dy, sq, shifted;
         dist_result_type r;
         ux = wide_type'(p[2]) - wide_type'(p[0]);
         uy = wide_type'(p[3]) - wide_type'(p[1]);
         vx = wide_type'(p[6]) - wide_type'(p[4]);
         vy = wide_type'(p[7]) - wide_type'(p[5]);
         wx = wide_type'(p[0]) - wide_type'(p[4]);
         wy = wide_type'(p[1]) - wide_type'(p[5]);
         a = ux * ux + uy * uy;
         b = ux * vx + uy * vy;
         c = vx * vx + vy * vy;
         d = ux * wx + uy * wy;
         e = vx * wx + vy * wy;
         det = a * c - b * b;
         sd = det;
         td = det;
         if (is_small(det)) begin
            // parallel: pin s to the start of the first segment
            sn = 0;
            sd = wide_type'(1) <<< 16;
            tn = e * 256;
            td = c * 256;
         end else begin
            sn = b * e - c * d;
            tn = a * e - b * d;
            if (sn < 0) begin
               sn = 0;
               tn = e * 256;
               td = c * 256;
            end else if (sn > sd) begin
               sn = sd;
               tn = (e + b) * 256;
               td = c * 256;
            end
         end
         if (tn < 0 || tn > td) begin
            if (tn < 0) begin
               tn = 0;
               m = -d;
            end else begin
               tn = td;
               m = b - d;
            end
            if (m < 0) sn = 0;
            else if (m > a) sn = sd;
            else begin
               sn = m * 256;
               sd = a * 256;
            end
         end
         s = clamp_ratio(sn, sd);
         t = clamp_ratio(tn, td);
         dx = (wx <<< PFB) + s * ux - t * vx;
         dy = (wy <<< PFB) + s * uy - t * vy;
         sq = dx * dx + dy * dy;
         shifted = sq >>> (2 * PFB);
         if (shifted > wide_type'(DIST_MAX)) begin
            r.dist_sq = DIST_MAX;
            r.saturated = 1'b1;
         end else begin
            r.dist_sq = shifted[OB-1:0];
            r.saturated = 1'b0;
         end
         return r;
      endfunction

      function void note_pair(pair_type p);
         pending = {pending, closest_dist_sq(p)};
      endfunction

      function void check_result(logic [OB-1:0] dist_sq, logic saturated);
         dist_result_type exp_r;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result dist_sq=%0d saturated=%0b",
                     $time, dist_sq, saturated);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         checked++;
         if (dist_sq !== exp_r.dist_sq) begin
            $display("%0t: dist_sq mismatch expected %0d actual %0d",
                     $time, exp_r.dist_sq, dist_sq);
            errors++;
         end
         if (saturated !== exp_r.saturated) begin
            $display("%0t: saturated mismatch expected %0b actual %0b",
                     $time, exp_r.saturated, saturated);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [TOLB-1:0] csr_wdata = '0;
   bit quiet = 1'b0;
   int idle_cycles = 0;
   int sent = 0;
   distance_scoreboard sb = new();

   ssd_req_if #(.CB(CB)) req_ch();
   ssd_rsp_if rsp_ch();

   segment_segment_distance_sq_core dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.first_start_x = '0;
      req_ch.first_start_y = '0;
      req_ch.first_end_x = '0;
      req_ch.first_end_y = '0;
      req_ch.second_start_x = '0;
      req_ch.second_start_y = '0;
      req_ch.second_end_x = '0;
      req_ch.second_end_y = '0;
      rsp_ch.ready = 1'b0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= quiet || ($urandom_range(99) >= 9);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            pair_type p;
            p[0] = req_ch.first_start_x;
            p[1] = req_ch.first_start_y;
            p[2] = req_ch.first_end_x;
            p[3] = req_ch.first_end_y;
            p[4] = req_ch.second_start_x;
            p[5] = req_ch.second_start_y;
            p[6] = req_ch.second_end_x;
            p[7] = req_ch.second_end_y;
            sb.note_pair(p);
         end
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_result(rsp_ch.dist_sq, rsp_ch.saturated);
      end
   end

   // watchdog on cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_pair(pair_type p);
      if (!quiet && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.first_start_x <= p[0];
      req_ch.first_start_y <= p[1];
      req_ch.first_end_x <= p[2];
      req_ch.first_end_y <= p[3];
      req_ch.second_start_x <= p[4];
      req_ch.second_start_y <= p[5];
      req_ch.second_end_x <= p[6];
      req_ch.second_end_y <= p[7];
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOLB-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.tolerance = value;
      @(posedge clock);
   endtask

   function automatic pair_type fill_pair(int p0x, int p0y, int p1x, int p1y,
                                          int q0x, int q0y, int q1x, int q1y);
      pair_type p;
      p[0] = coord_type'(p0x);
      p[1] = coord_type'(p0y);
      p[2] = coord_type'(p1x);
      p[3] = coord_type'(p1y);
      p[4] = coord_type'(q0x);
      p[5] = coord_type'(q0y);
      p[6] = coord_type'(q1x);
      p[7] = coord_type'(q1y);
      return p;
   endfunction

   function automatic coord_type small_coord(int span);
      return coord_type'($signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int dx, dy, k;
      case ($urandom_range(5))
         0, 1: begin
            for (int i = 0; i < 8; i++) p[i] = coord_type'($urandom);
         end
         2: begin
            for (int i = 0; i < 8; i++) p[i] = small_coord(64);
         end
         3: begin
            // parallel or nearly parallel segments
            dx = $signed($urandom_range(200)) - 100;
            dy = $signed($urandom_range(200)) - 100;
            k = $urandom_range(4, 1);
            p[0] = small_coord(2000);
            p[1] = small_coord(2000);
            p[2] = coord_type'(p[0] + dx);
            p[3] = coord_type'(p[1] + dy);
            p[4] = coord_type'(p[0] + small_coord(300));
            p[5] = coord_type'(p[1] + small_coord(300));
            p[6] = coord_type'(p[4] + k * dx + small_coord(1));
            p[7] = coord_type'(p[5] + k * dy + small_coord(1));
         end
         4: begin
            // degenerate segments
            for (int i = 0; i < 8; i++) p[i] = small_coord(1000);
            if ($urandom_range(1)) begin
               p[2] = p[0];
               p[3] = p[1];
            end
            if ($urandom_range(1)) begin
               p[6] = p[4];
               p[7] = p[5];
            end
         end
         default: begin
            // shared or crossing endpoints
            for (int i = 0; i < 8; i++) p[i] = small_coord(8000);
            p[4] = p[$urandom_range(1) ? 0 : 2];
            p[5] = p[4] == p[0] ? p[1] : p[3];
         end
      endcase
      return p;
   endfunction

   initial begin
      logic [TOLB-1:0] tol_plan [6];
      tol_plan = '{16'd0, 16'hFFFF, 16'd1, ssd_pkg::TOL_RESET, 16'd0, 16'd0};
      tol_plan[4] = TOLB'($urandom);
      tol_plan[5] = TOLB'($urandom_range(300));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(fill_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      send_pair(fill_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(fill_pair(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
      send_pair(fill_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
      send_pair(fill_pair(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
      send_pair(fill_pair(0, 0, 160, 0, 80, -80, 80, 80));
      send_pair(fill_pair(0, 0, 160, 0, 0, 32, 160, 32));
      send_pair(fill_pair(0, 0, 160, 0, 320, 32, 480, 32));
      send_pair(fill_pair(0, 0, 160, 0, -320, 32, -160, 32));
      send_pair(fill_pair(16, 16, 16, 16, 0, 0, 64, 0));
      send_pair(fill_pair(0, 0, 64, 0, 16, 16, 16, 16));
      send_pair(fill_pair(5, 5, 5, 5, -7, 9, -7, 9));
      send_pair(fill_pair(0, 0, 1, 0, 0, 1, 1, 1));
      send_pair(fill_pair(0, 0, 1, 1, 0, 1, 1, 0));
      send_pair(fill_pair(0, 0, 100, 0, 200, 50, 300, 10));
      send_pair(fill_pair(0, 0, 100, 0, -200, 50, -100, 10));
      send_pair(fill_pair(0, 0, 100, 100, 50, 0, 50, -300));
      send_pair(fill_pair(0, 0, 100, 1, 0, 3, 100, 4));
      send_pair(fill_pair(-1, -1, 1, 1, 1, -1, -1, 1));
      send_pair(fill_pair(32767, -32768, -32768, 32767, 0, 0, 0, 0));
      drain();

      foreach (tol_plan[ph]) begin
         write_tolerance(tol_plan[ph]);
         for (int n = 0; n < 135; n++) begin
            quiet = (ph == 2);
            send_pair(random_pair());
         end
         quiet = 1'b0;
         drain();
      end

      $display("covered %0d segment pairs, %0d results checked, %0d tolerance settings",
               sent, sb.checked, $size(tol_plan) + 1);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
